// ===== hdl/tsre_pkg.sv =====
// Shared types and constants for the transparent sprite RLE encoder.
// No dependencies; every other file in hdl/ but tsre_ram imports this package.
package tsre_pkg;

    // Palette and row geometry
    localparam int MAX_WIDTH   = 4096;
    localparam int PAL_DEPTH   = 256;
    localparam int PAL_AW      = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
    localparam int COL_W       = $clog2(MAX_WIDTH + 1);
    localparam int LW_W        = 13;
    localparam int WORD_W      = 32;
    localparam int LEN_W       = 16;

    // Writes per pixel and queue sizing
    localparam int SLOTS       = 4;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int QUEUE_DEPTH = 4;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    // Input operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // Configuration register indexes
    localparam logic REG_TRANSPARENT = 1'b0;
    localparam logic REG_LINE_WIDTH  = 1'b1;

    // Record kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_SKIP = 2'd1;
    localparam logic [1:0] KIND_COPY = 2'd2;
    localparam logic [1:0] KIND_HEAD = 2'd3;

    // Write sizes
    localparam logic SIZE_BYTE = 1'b0;
    localparam logic SIZE_WORD = 1'b1;

    // One buffer write
    typedef struct packed {
        logic [WORD_W-1:0] byte_offset;
        logic [WORD_W-1:0] write_value;
        logic              write_size;
        logic [1:0]        record_kind;
    } write_t;

    // All writes caused by one pixel, in order; last_slot is count minus one
    typedef struct packed {
        write_t [SLOTS-1:0] slot;
        logic [SLOT_W-1:0]  last_slot;
    } burst_t;

endpackage

// ===== hdl/tsre_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; hold the data while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/tsre_front.sv =====
// Front end: input transfer, palette lookup, transparency test and run encoding.
// Depends on tsre_pkg and tsre_ram; pushes one burst of writes per pixel that has writes.
module tsre_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [31:0]             cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    operation,
    input  logic [7:0]              color_index,
    input  logic [31:0]             color_value,
    output logic                    push_valid,
    input  logic                    push_ready,
    output tsre_pkg::burst_t        push_data
);
    import tsre_pkg::*;

    // Configuration
    logic [WORD_W-1:0] transp_reg;
    logic [LW_W-1:0]   lw_reg;

    // Lookup stage
    logic              b_valid_reg, b_valid_next;
    logic [7:0]        b_idx_reg;
    logic              b_in_range_reg;

    // Run state
    logic              copy_reg, copy_next;
    logic [LEN_W-1:0]  rl_reg, rl_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [WORD_W-1:0] rec_reg, rec_next;
    logic [WORD_W-1:0] data_reg, data_next;
    logic [WORD_W-1:0] hdr_reg, hdr_next;
    logic [LEN_W-1:0]  rb_reg, rb_next;

    logic              accept;
    logic              advance;
    logic              in_range;
    logic [PAL_AW-1:0] pal_addr;
    logic [WORD_W-1:0] pal_rdata;
    logic [WORD_W-1:0] colour;
    logic              transp;
    logic [31:0]       lw32;
    logic [COL_W-1:0]  width_eff;
    logic [COL_W:0]    col_inc;
    logic              end_row;
    logic [WORD_W-1:0] rec_p4, rec_p8, rec_p9, data_p1, data_p4;
    logic [SLOT_W:0]   n_writes;
    burst_t            burst;

    assign in_range = 32'(color_index) < PAL_DEPTH;
    assign pal_addr = PAL_AW'(color_index);
    assign accept   = in_valid && in_ready;

    // Stall the lookup stage only when it has writes and the queue is full
    assign advance  = b_valid_reg && (push_ready || (n_writes == '0));
    assign in_ready = !b_valid_reg || advance;

    assign push_valid = b_valid_reg && (n_writes != '0);
    assign push_data  = burst;

    tsre_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PAL_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (accept && (operation == OP_LOAD) && in_range),
        .waddr (pal_addr),
        .wdata (color_value),
        .re    (accept && (operation == OP_PIXEL)),
        .raddr (pal_addr),
        .rdata (pal_rdata)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transp_reg <= '0;
            lw_reg     <= LW_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TRANSPARENT: transp_reg <= cfg_wdata;
                REG_LINE_WIDTH:  lw_reg     <= cfg_wdata[LW_W-1:0];
                default:         transp_reg <= transp_reg;
            endcase
        end
    end

    // Classify the looked-up pixel
    assign colour = b_in_range_reg ? pal_rdata : '0;
    assign transp = (colour == transp_reg);

    // Clamp the row width to one..MAX_WIDTH
    assign lw32 = 32'(lw_reg);
    always_comb
    begin
        priority if (lw32 == 32'd0)
            width_eff = COL_W'(1);
        else if (lw32 > MAX_WIDTH)
            width_eff = COL_W'(MAX_WIDTH);
        else
            width_eff = COL_W'(lw32);
    end

    assign col_inc = {1'b0, col_reg} + (COL_W + 1)'(1);
    assign end_row = col_inc >= {1'b0, width_eff};

    // Candidate offsets, all taken from the registers in parallel
    assign rec_p4  = rec_reg + 32'd4;
    assign rec_p8  = rec_reg + 32'd8;
    assign rec_p9  = rec_reg + 32'd9;
    assign data_p1 = data_reg + 32'd1;
    assign data_p4 = data_reg + 32'd4;

    // Encode one pixel: next run state and its ordered writes
    always_comb
    begin
        logic [WORD_W-1:0] rec_n_p4;
        logic [1:0]        close_kind;

        copy_next = copy_reg;
        rl_next   = rl_reg;
        rec_next  = rec_reg;
        data_next = data_reg;
        hdr_next  = hdr_reg;
        rb_next   = rb_reg;
        col_next  = col_inc[COL_W-1:0];
        burst     = '0;
        n_writes  = '0;
        rec_n_p4  = rec_p4;
        close_kind = KIND_SKIP;

        priority if (col_reg == '0)
        begin
            // Row start: reserve the header, open the first run
            hdr_next = rec_reg;
            rec_next = rec_p4;
            rec_n_p4 = rec_p8;
            rl_next  = LEN_W'(1);
            if (transp)
            begin
                copy_next = 1'b0;
                data_next = rec_p8;
                rb_next   = LEN_W'(8);
            end
            else
            begin
                copy_next = 1'b1;
                burst.slot[n_writes[SLOT_W-1:0]] = '{rec_p8, {24'd0, b_idx_reg},
                                                    SIZE_BYTE, KIND_DATA};
                n_writes  = n_writes + 1'b1;
                data_next = rec_p9;
                rb_next   = LEN_W'(9);
            end
        end
        else if (transp)
        begin
            if (!copy_reg)
            begin
                rl_next = rl_reg + LEN_W'(1);
            end
            else
            begin
                // Close the copy run; the next record follows its data
                burst.slot[n_writes[SLOT_W-1:0]] = '{rec_reg, {14'd0, KIND_COPY, rl_reg},
                                                    SIZE_WORD, KIND_COPY};
                n_writes  = n_writes + 1'b1;
                rec_next  = data_reg;
                rec_n_p4  = data_p4;
                rl_next   = LEN_W'(1);
                copy_next = 1'b0;
                rb_next   = rb_reg + LEN_W'(4);
            end
        end
        else
        begin
            if (copy_reg)
            begin
                rl_next = rl_reg + LEN_W'(1);
                burst.slot[n_writes[SLOT_W-1:0]] = '{data_reg, {24'd0, b_idx_reg},
                                                    SIZE_BYTE, KIND_DATA};
                n_writes  = n_writes + 1'b1;
                data_next = data_p1;
                rb_next   = rb_reg + LEN_W'(1);
            end
            else
            begin
                // Close the skip run, open a copy run with its first byte
                burst.slot[n_writes[SLOT_W-1:0]] = '{rec_reg, {14'd0, KIND_SKIP, rl_reg},
                                                    SIZE_WORD, KIND_SKIP};
                n_writes = n_writes + 1'b1;
                rec_next = rec_p4;
                burst.slot[n_writes[SLOT_W-1:0]] = '{rec_p8, {24'd0, b_idx_reg},
                                                    SIZE_BYTE, KIND_DATA};
                n_writes  = n_writes + 1'b1;
                data_next = rec_p9;
                rl_next   = LEN_W'(1);
                copy_next = 1'b1;
                rb_next   = rb_reg + LEN_W'(5);
            end
        end

        // Row end: close the open run, then write the header
        if (end_row)
        begin
            close_kind = copy_next ? KIND_COPY : KIND_SKIP;
            burst.slot[n_writes[SLOT_W-1:0]] = '{rec_next, {14'd0, close_kind, rl_next},
                                                SIZE_WORD, close_kind};
            n_writes = n_writes + 1'b1;
            rec_next = copy_next ? data_next : rec_n_p4;
            burst.slot[n_writes[SLOT_W-1:0]] = '{hdr_next, {16'd0, rb_next},
                                                SIZE_WORD, KIND_HEAD};
            n_writes = n_writes + 1'b1;
            col_next = '0;
        end

        burst.last_slot = SLOT_W'(n_writes - 1'b1);
    end

    // Lookup stage control
    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (in_ready)
        begin
            b_valid_next = accept && (operation == OP_PIXEL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
        end
    end

    // Pixel payload for the lookup stage
    always_ff @(posedge clk)
    begin
        if (accept && (operation == OP_PIXEL))
        begin
            b_idx_reg      <= color_index;
            b_in_range_reg <= in_range;
        end
    end

    // Advance the run state once per encoded pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            copy_reg <= 1'b0;
            rl_reg   <= '0;
            col_reg  <= '0;
            rec_reg  <= '0;
            data_reg <= '0;
            hdr_reg  <= '0;
            rb_reg   <= '0;
        end
        else if (advance)
        begin
            copy_reg <= copy_next;
            rl_reg   <= rl_next;
            col_reg  <= col_next;
            rec_reg  <= rec_next;
            data_reg <= data_next;
            hdr_reg  <= hdr_next;
            rb_reg   <= rb_next;
        end
    end

endmodule

// ===== hdl/tsre_queue.sv =====
// Short queue of write bursts between the front end and the write sequencer.
// Depends on tsre_pkg.
module tsre_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  tsre_pkg::burst_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output tsre_pkg::burst_t pop_data
);
    import tsre_pkg::*;

    burst_t          entry_reg [QUEUE_DEPTH];
    logic [QA_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QA_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != QC_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming burst
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/tsre_back.sv =====
// Write sequencer: hands out the writes of the head burst one transfer at a time.
// Depends on tsre_pkg.
module tsre_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  tsre_pkg::burst_t pop_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [31:0]      byte_offset,
    output logic [31:0]      write_value,
    output logic             write_size,
    output logic [1:0]       record_kind,
    output logic             last
);
    import tsre_pkg::*;

    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              is_last;
    write_t            cur;

    assign cur       = pop_data.slot[slot_reg];
    assign is_last   = (slot_reg == pop_data.last_slot);
    assign out_valid = pop_valid;
    assign pop_ready = out_ready && is_last;

    assign byte_offset = cur.byte_offset;
    assign write_value = cur.write_value;
    assign write_size  = cur.write_size;
    assign record_kind = cur.record_kind;
    assign last        = is_last;

    // Advance through the burst; drop it after its final transfer
    always_comb
    begin
        slot_next = slot_reg;
        if (out_valid && out_ready)
        begin
            slot_next = is_last ? '0 : slot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

// ===== hdl/transparent_sprite_rle_encoder_core.sv =====
// Transparent sprite RLE encoder, top level. Load the palette with operation 0
// items, then stream palette-index pixels row by row with operation 1; each
// pixel gives zero to four byte-addressed buffer writes (data bytes, skip/copy
// records and, at the end of a row, the row header), the final one of each
// pixel flagged by last. One input transfer is taken per cycle while the
// four-entry burst queue has room; the palette RAM read is registered, so
// a pixel reaches the encoder in the cycle after it is taken. The write
// port moves one write per cycle while out_ready is high, so the sustained
// pixel rate is one per cycle on runs, lower at run changes and row ends.
// Depends on tsre_pkg, tsre_front, tsre_queue and tsre_back.
module transparent_sprite_rle_encoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [7:0]  color_index,
    input  logic [31:0] color_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] byte_offset,
    output logic [31:0] write_value,
    output logic        write_size,
    output logic [1:0]  record_kind,
    output logic        last
);
    import tsre_pkg::*;

    logic   push_valid;
    logic   push_ready;
    burst_t push_data;
    logic   pop_valid;
    logic   pop_ready;
    burst_t pop_data;

    tsre_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .color_index (color_index),
        .color_value (color_value),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    tsre_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    tsre_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .byte_offset (byte_offset),
        .write_value (write_value),
        .write_size  (write_size),
        .record_kind (record_kind),
        .last        (last)
    );

endmodule

// ===== dv/transparent_sprite_rle_encoder_core_tb.sv =====
// Testbench for transparent_sprite_rle_encoder_core: a directed table, then random
// palette loads and sprite rows, every buffer write checked against a local encoder model.
// Depends on tsre_pkg and the encoder RTL only.
`timescale 1ns / 100ps

module transparent_sprite_rle_encoder_core_tb;
    import tsre_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 16;
    localparam int NUM_PHASES    = 12;
    localparam int PHASE_PIXELS  = 24;

    // Line widths per random phase: extremes, clamped and zero among them
    localparam logic [12:0] PHASE_WIDTH [NUM_PHASES] =
        '{13'd1, 13'd4096, 13'd2, 13'd7, 13'd4097, 13'd16,
          13'd0, 13'd3, 13'd33, 13'd8191, 13'd5, 13'd12};

    // One buffer write as seen on the result port
    typedef struct packed {
        logic [31:0] offs;
        logic [31:0] word;
        logic        wsize;
        logic [1:0]  kind;
        logic        is_last;
    } buf_write_t;

    // Directed table: an input transfer or a register write
    typedef enum logic {ROW_ITEM, ROW_REG} row_act_t;

    typedef struct packed {
        row_act_t    act;
        logic        op;
        logic        regsel;
        logic [7:0]  idx;
        logic [31:0] value;
        logic        typed;
        logic [31:0] t_offs;
        logic [31:0] t_word;
        logic [1:0]  t_kind;
    } stim_row_t;

    // Typed rows give the row header, the final write of the pixel
    localparam stim_row_t DIRECTED [25] = '{
        '{ROW_ITEM, OP_LOAD,  REG_TRANSPARENT, 8'd0,   32'h0000_0000, 1'b0, 32'd0,  32'd0, KIND_DATA},
        '{ROW_ITEM, OP_LOAD,  REG_TRANSPARENT, 8'd255, 32'hFFFF_FFFF, 1'b0, 32'd0,  32'd0, KIND_DATA},
        '{ROW_ITEM, OP_LOAD,  REG_TRANSPARENT, 8'd1,   32'h0000_1234, 1'b0, 32'd0,  32'd0, KIND_DATA},
        '{ROW_ITEM, OP_LOAD,  REG_TRANSPARENT, 8'd2,   32'h8000_0000, 1'b0, 32'd0,  32'd0, KIND_DATA},
        '{ROW_ITEM, OP_PIXEL, REG_TRANSPARENT, 8'd0,   32'h0000_0000, 1'b1, 32'd0,  32'd8, KIND_HEAD},
        '{ROW_ITEM, OP_PIXEL, REG_TRANSPARENT, 8'd255, 32'hDEAD_BEEF, 1'b1, 32'd8,  32'd9, KIND_HEAD},
        '{ROW_REG,  OP_LOAD,  REG_LINE_WIDTH,  8'd0,   32'h0000_0000, 1'b0, 32'd0,  32'd0, KIND_DATA},
        '{ROW_ITEM, OP_PIXEL, REG_TRANSPARENT, 8'd1,   32'hFFFF_FFFF, 1'b1, 32'd17, 32'd9, KIND_HEAD},
        '{ROW_REG,  OP_LOAD,  REG_LINE_WIDTH,  8'd0,   32'hFFFF_FFFF, 1'b0, 32'd0,  32'd0, KIND_DATA},
        '{ROW_REG,  OP_LOAD,  REG_TRANSPARENT, 8'd0,   32'hFFFF_FFFF, 1'b0, 32'd0,  32'd0, KIND_DATA},
        '{ROW_ITEM, OP_PIXEL, REG_TRANSPARENT, 8'd255, 32'h0000_0000, 1'b0, 32'd0,  32'd0, KIND_DATA},
        '{ROW_ITEM, OP_PIXEL, REG_TRANSPARENT, 8'd255, 32'h5555_5555, 1'b0, 32'd0,  32'd0, KIND_DATA},
        '{ROW_ITEM, OP_PIXEL, REG_TRANSPARENT, 8'd0,   32'hAAAA_AAAA, 1'b0, 32'd0,  32'd0, KIND_DATA},
        '{ROW_ITEM, OP_PIXEL, REG_TRANSPARENT, 8'd2,   32'h0000_0000, 1'b0, 32'd0,  32'd0, KIND_DATA},
        '{ROW_ITEM, OP_PIXEL, REG_TRANSPARENT, 8'd255, 32'h0000_0000, 1'b0, 32'd0,  32'd0, KIND_DATA},
        '{ROW_ITEM, OP_PIXEL, REG_TRANSPARENT, 8'd1,   32'h0000_0000, 1'b0, 32'd0,  32'd0, KIND_DATA},
        '{ROW_REG,  OP_LOAD,  REG_LINE_WIDTH,  8'd0,   32'h0000_0003, 1'b0, 32'd0,  32'd0, KIND_DATA},
        '{ROW_ITEM, OP_PIXEL, REG_TRANSPARENT, 8'd1,   32'h0000_0000, 1'b0, 32'd0,  32'd0, KIND_DATA},
        '{ROW_REG,  OP_LOAD,  REG_TRANSPARENT, 8'd0,   32'h0000_1234, 1'b0, 32'd0,  32'd0, KIND_DATA},
        '{ROW_ITEM, OP_PIXEL, REG_TRANSPARENT, 8'd1,   32'h0000_0000, 1'b0, 32'd0,  32'd0, KIND_DATA},
        '{ROW_ITEM, OP_PIXEL, REG_TRANSPARENT, 8'd255, 32'h0000_0000, 1'b0, 32'd0,  32'd0, KIND_DATA},
        '{ROW_ITEM, OP_PIXEL, REG_TRANSPARENT, 8'd1,   32'h0000_0000, 1'b0, 32'd0,  32'd0, KIND_DATA},
        '{ROW_ITEM, OP_PIXEL, REG_TRANSPARENT, 8'd1,   32'h0000_0000, 1'b0, 32'd0,  32'd0, KIND_DATA},
        '{ROW_ITEM, OP_PIXEL, REG_TRANSPARENT, 8'd1,   32'h0000_0000, 1'b0, 32'd0,  32'd0, KIND_DATA},
        '{ROW_ITEM, OP_PIXEL, REG_TRANSPARENT, 8'd255, 32'h0000_0000, 1'b0, 32'd0,  32'd0, KIND_DATA}
    };

    // Block ports
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic        cfg_index   = REG_TRANSPARENT;
    logic [31:0] cfg_wdata   = '0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic        operation   = OP_LOAD;
    logic [7:0]  color_index = '0;
    logic [31:0] color_value = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [31:0] byte_offset;
    logic [31:0] write_value;
    logic        write_size;
    logic [1:0]  record_kind;
    logic        last;

    // Encoder mirror: palette, registers and row state
    logic [31:0] pal [PAL_DEPTH];
    bit          pal_loaded [PAL_DEPTH];
    logic [31:0] transp_colour = '0;
    logic [12:0] width_reg     = 13'd1;
    logic        in_copy       = 1'b0;
    logic [15:0] run_len       = '0;
    logic [12:0] col           = '0;
    logic [31:0] rec_off       = '0;
    logic [31:0] dat_off       = '0;
    logic [31:0] hdr_off       = '0;
    logic [15:0] row_len       = '0;

    buf_write_t  expected_writes [$];
    int          fail_count = 0;
    int          idle_level = 0;

    transparent_sprite_rle_encoder_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .color_index (color_index),
        .color_value (color_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .byte_offset (byte_offset),
        .write_value (write_value),
        .write_size  (write_size),
        .record_kind (record_kind),
        .last        (last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Record word for the run that is closing, at the current record address
    function automatic buf_write_t run_record_write(logic [1:0] kind);
        return '{rec_off, {14'd0, kind, run_len}, SIZE_WORD, kind, 1'b0};
    endfunction

    // Data byte at the current data address; advance that address
    function automatic buf_write_t data_byte_write(logic [7:0] idx);
        buf_write_t w;
        w = '{dat_off, {24'd0, idx}, SIZE_BYTE, KIND_DATA, 1'b0};
        dat_off += 32'd1;
        return w;
    endfunction

    // Update the mirror for one accepted transfer and queue the writes it causes
    function automatic void predict_writes(logic op, logic [7:0] idx, logic [31:0] val);
        buf_write_t batch [$];
        logic       transp;
        int         eff_w;
        if (op == OP_LOAD) begin
            pal[idx]        = val;
            pal_loaded[idx] = 1'b1;
        end else begin
            transp = (pal[idx] == transp_colour);
            if (col == '0) begin
                // row start: reserve the header word
                hdr_off = rec_off;
                rec_off += 32'd4;
                dat_off = rec_off + 32'd4;
                row_len = 16'd4;
                run_len = 16'd1;
                in_copy = !transp;
                if (transp) begin
                    row_len += 16'd4;
                end else begin
                    batch.push_back(data_byte_write(idx));
                    row_len += 16'd5;
                end
            end else if (transp) begin
                if (!in_copy) begin
                    run_len += 16'd1;
                end else begin
                    // copy run closes; the next record follows its data
                    batch.push_back(run_record_write(KIND_COPY));
                    rec_off = dat_off;
                    run_len = 16'd1;
                    in_copy = 1'b0;
                    row_len += 16'd4;
                end
            end else if (in_copy) begin
                run_len += 16'd1;
                batch.push_back(data_byte_write(idx));
                row_len += 16'd1;
            end else begin
                // skip run closes; a copy record and its data follow
                batch.push_back(run_record_write(KIND_SKIP));
                rec_off += 32'd4;
                dat_off = rec_off + 32'd4;
                run_len = 16'd1;
                in_copy = 1'b1;
                batch.push_back(data_byte_write(idx));
                row_len += 16'd5;
            end

            eff_w = (width_reg == '0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
            col += 13'd1;
            if (int'(col) >= eff_w) begin
                // row end: close the open run, then the header
                if (!in_copy) begin
                    batch.push_back(run_record_write(KIND_SKIP));
                    rec_off += 32'd4;
                end else begin
                    batch.push_back(run_record_write(KIND_COPY));
                    rec_off = dat_off;
                end
                batch.push_back('{hdr_off, {16'd0, row_len}, SIZE_WORD, KIND_HEAD, 1'b0});
                col = '0;
            end

            if (batch.size() != 0)
                batch[batch.size() - 1].is_last = 1'b1;
            foreach (batch[k])
                expected_writes.push_back(batch[k]);
        end
    endfunction

    // Loaded palette entry whose transparency matches, from a random start; else the first loaded one
    function automatic logic [7:0] pick_palette_index(logic want_transp);
        int         start;
        logic [7:0] k;
        logic [7:0] fallback;
        bit         have_fallback;
        start         = $urandom_range(0, PAL_DEPTH - 1);
        fallback      = '0;
        have_fallback = 1'b0;
        for (int j = 0; j < PAL_DEPTH; j++) begin
            k = 8'(start + j);
            if (pal_loaded[k]) begin
                if ((pal[k] == transp_colour) == want_transp)
                    return k;
                if (!have_fallback) begin
                    fallback      = k;
                    have_fallback = 1'b1;
                end
            end
        end
        return fallback;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Hold one input transfer until it is taken, then predict it
    task automatic push_item(logic op, logic [7:0] idx, logic [31:0] val);
        cfg_we      <= 1'b0;
        in_valid    <= 1'b1;
        operation   <= op;
        color_index <= idx;
        color_value <= val;
        do
            @(posedge clk);
        while (!in_ready);
        predict_writes(op, idx, val);
    endtask

    // Drop valid for a random burst when this phase idles
    task automatic maybe_pause();
        if (idle_level != 0 && $urandom_range(0, 9) < idle_level) begin
            in_valid <= 1'b0;
            cfg_we   <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Hold off until every queued write is out and the pipeline has settled
    task automatic drain();
        in_valid <= 1'b0;
        cfg_we   <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic regsel, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= regsel;
        cfg_wdata <= data;
        @(posedge clk);
        if (regsel == REG_TRANSPARENT)
            transp_colour = data;
        else
            width_reg = data[12:0];
    endtask

    // Stimulus: reset, directed table, random phases, then wind down
    initial begin
        logic [7:0]  idx;
        logic [31:0] tc;
        logic [31:0] wdata;
        logic        want_transp;
        stim_row_t   row;

        want_transp = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        idle_level = 2;
        foreach (DIRECTED[r]) begin
            row = DIRECTED[r];
            if (row.act == ROW_REG) begin
                drain();
                write_reg(row.regsel, row.value);
            end else begin
                maybe_pause();
                push_item(row.op, row.idx, row.value);
                if (row.typed) begin
                    void'(expected_writes.pop_back());
                    expected_writes.push_back('{row.t_offs, row.t_word, SIZE_WORD,
                                                row.t_kind, 1'b1});
                end
            end
        end

        // Random phases: set colour and width, four loads, then rows of pixels
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            idle_level = (p >= NUM_PHASES - 2) ? 0 : $urandom_range(0, 3);
            case ($urandom_range(0, 3))
                0:       tc = $urandom();
                1:       tc = pal[pick_palette_index(1'($urandom_range(0, 1)))];
                2:       tc = '0;
                default: tc = transp_colour;
            endcase
            write_reg(REG_TRANSPARENT, tc);
            wdata       = $urandom();
            wdata[12:0] = PHASE_WIDTH[p];
            write_reg(REG_LINE_WIDTH, wdata);

            for (int i = 0; i < 4; i++) begin
                maybe_pause();
                idx = 8'($urandom_range(0, PAL_DEPTH - 1));
                push_item(OP_LOAD, idx, (i < 2) ? tc : $urandom());
            end

            for (int i = 0; i < PHASE_PIXELS; i++) begin
                maybe_pause();
                if ($urandom_range(0, 9) == 0) begin
                    // stray load in the middle of a row
                    idx = 8'($urandom_range(0, PAL_DEPTH - 1));
                    push_item(OP_LOAD, idx, $urandom_range(0, 1) ? tc : $urandom());
                end else begin
                    // runs: keep the current kind most of the time
                    if ($urandom_range(0, 3) == 0)
                        want_transp = !want_transp;
                    idx = pick_palette_index(want_transp);
                    push_item(OP_PIXEL, idx, $urandom());
                end
            end
        end

        in_valid <= 1'b0;
        cfg_we   <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_writes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Result side: stall in random bursts while the phase idles
    initial begin
        int stall_left;
        stall_left = 0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (idle_level != 0 && $urandom_range(0, 9) < idle_level) begin
                stall_left = $urandom_range(0, 16);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Compare each write transfer with the oldest expectation
    always @(posedge clk) begin
        buf_write_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_writes.size() == 0) begin
                $error("write with none expected: byte_offset %0h, write_value %0h",
                       byte_offset, write_value);
                fail_count++;
            end else begin
                want = expected_writes.pop_front();
                check_field("byte_offset", want.offs, byte_offset);
                check_field("write_value", want.word, write_value);
                check_field("write_size", 32'(want.wsize), 32'(write_size));
                check_field("record_kind", 32'(want.kind), 32'(record_kind));
                check_field("last", 32'(want.is_last), 32'(last));
            end
        end
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
